/* rtl/adc_frame_average_scaler_core_defines.svh */
// Assertion macros for the RTL datapath
`ifndef ADC_FRAME_AVERAGE_SCALER_CORE_DEFINES_SVH
`define ADC_FRAME_AVERAGE_SCALER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define AFAS_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("afas: assertion failed");
`define AFAS_ASSERT_RST(name, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("afas: reset assertion failed");
`else
`define AFAS_ASSERT(name, prop)
`define AFAS_ASSERT_RST(name, prop)
`endif

`endif

/* rtl/afas_pkg.sv */
package afas_pkg;

  localparam int FRAME_DEPTH = 32;
  localparam int SAMPLE_BITS = 12;
  localparam int NUM_CH      = 5;

  localparam int CNT_W  = $clog2(FRAME_DEPTH + 1);
  localparam int EXT_W  = $clog2(FRAME_DEPTH);
  localparam int SUM_W  = SAMPLE_BITS + EXT_W;
  localparam int REM_W  = CNT_W + 1;
  localparam int STEP_W = $clog2(SAMPLE_BITS);
  localparam int CH_W   = 3;
  localparam int PC_W   = 4;
  localparam int GAIN_W = 32;
  localparam int MOP_W  = SAMPLE_BITS + 2;
  localparam int PROD_W = MOP_W + GAIN_W;

  // channel slots
  localparam logic [CH_W-1:0] CH_VOLT  = 3'd0;
  localparam logic [CH_W-1:0] CH_IREF  = 3'd1;
  localparam logic [CH_W-1:0] CH_IMEAS = 3'd2;
  localparam logic [CH_W-1:0] CH_MAG   = 3'd3;
  localparam logic [CH_W-1:0] CH_TEMP  = 3'd4;

  // register index, taken from paddr[2]
  localparam logic REG_VGAIN = 1'b0;
  localparam logic REG_IGAIN = 1'b1;
  localparam logic signed [GAIN_W-1:0] GAIN_RESET = 32'sd65536;

  typedef enum logic [2:0] {
    OP_ACCEPT,
    OP_DIV_LOAD,
    OP_DIV_STEP,
    OP_MUL_V,
    OP_SAT_V,
    OP_MUL_I,
    OP_SAT_I,
    OP_EMIT
  } op_t;

  typedef enum logic [1:0] {
    COND_NEXT,
    COND_NO_DRAIN,
    COND_DIV_BUSY,
    COND_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t             op;
    logic [CH_W-1:0] ch;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ctl_t;

  typedef struct packed {
    logic drain_go;
    logic div_busy;
    logic out_busy;
  } stat_t;

  // control store: a condition that holds jumps to target, else fall through
  function automatic ctl_t ucode(input logic [PC_W-1:0] pc);
    ctl_t w;
    case (pc)
      4'd0:    w = '{OP_ACCEPT,   CH_VOLT,  COND_NO_DRAIN, 4'd0};
      4'd1:    w = '{OP_DIV_LOAD, CH_VOLT,  COND_NEXT,     4'd0};
      4'd2:    w = '{OP_DIV_STEP, CH_VOLT,  COND_DIV_BUSY, 4'd2};
      4'd3:    w = '{OP_DIV_LOAD, CH_IREF,  COND_NEXT,     4'd0};
      4'd4:    w = '{OP_DIV_STEP, CH_IREF,  COND_DIV_BUSY, 4'd4};
      4'd5:    w = '{OP_DIV_LOAD, CH_IMEAS, COND_NEXT,     4'd0};
      4'd6:    w = '{OP_DIV_STEP, CH_IMEAS, COND_DIV_BUSY, 4'd6};
      4'd7:    w = '{OP_DIV_LOAD, CH_MAG,   COND_NEXT,     4'd0};
      4'd8:    w = '{OP_DIV_STEP, CH_MAG,   COND_DIV_BUSY, 4'd8};
      4'd9:    w = '{OP_DIV_LOAD, CH_TEMP,  COND_NEXT,     4'd0};
      4'd10:   w = '{OP_DIV_STEP, CH_TEMP,  COND_DIV_BUSY, 4'd10};
      4'd11:   w = '{OP_MUL_V,    CH_VOLT,  COND_NEXT,     4'd0};
      4'd12:   w = '{OP_SAT_V,    CH_VOLT,  COND_NEXT,     4'd0};
      4'd13:   w = '{OP_MUL_I,    CH_VOLT,  COND_NEXT,     4'd0};
      4'd14:   w = '{OP_SAT_I,    CH_VOLT,  COND_NEXT,     4'd0};
      4'd15:   w = '{OP_EMIT,     CH_VOLT,  COND_OUT_BUSY, 4'd15};
      default: w = '{OP_ACCEPT,   CH_VOLT,  COND_NO_DRAIN, 4'd0};
    endcase
    return w;
  endfunction

endpackage

/* rtl/afas_seq.sv */
module afas_seq
  import afas_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  stat_t stat,
  output ctl_t  ctl
);

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  logic            jump;

  assign ctl = ucode(pc);

  always_comb begin
    case (ctl.cond)
      COND_NEXT:     jump = 1'b0;
      COND_NO_DRAIN: jump = !stat.drain_go;
      COND_DIV_BUSY: jump = stat.div_busy;
      COND_OUT_BUSY: jump = stat.out_busy;
      default:       jump = 1'b0;
    endcase
  end

  // last step falls through to step 0 by wrap-around
  always_comb begin
    pc_next = jump ? ctl.target : pc + PC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

/* rtl/afas_datapath.sv */
`include "adc_frame_average_scaler_core_defines.svh"

module afas_datapath
  import afas_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  ctl_t                     ctl,
  output stat_t                    stat,
  input  logic signed [GAIN_W-1:0] voltage_gain,
  input  logic signed [GAIN_W-1:0] current_gain,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     command,
  input  logic [11:0]              voltage_sample,
  input  logic [11:0]              iref_sample,
  input  logic [11:0]              imeas_sample,
  input  logic [11:0]              magnet_sample,
  input  logic [11:0]              temperature_sample,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [31:0]       voltage_scaled,
  output logic signed [31:0]       current_feedback,
  output logic [11:0]              iref_average,
  output logic [11:0]              imeas_average,
  output logic [11:0]              magnet_average,
  output logic [11:0]              temperature_average,
  output logic [5:0]               frames_used
);

  logic [SUM_W-1:0]         sums [NUM_CH];
  logic [SAMPLE_BITS-1:0]   smp  [NUM_CH];
  logic [SAMPLE_BITS-1:0]   avg  [NUM_CH];
  logic [CNT_W-1:0]         frames_held;

  logic [REM_W-1:0]         rem;
  logic [REM_W-1:0]         trial;
  logic [REM_W-1:0]         rem_next;
  logic                     ge;
  logic [SAMPLE_BITS-1:0]   dshift;
  logic [SAMPLE_BITS-1:0]   quo;
  logic [SAMPLE_BITS-1:0]   quo_next;
  logic [STEP_W-1:0]        step_cnt;

  logic signed [MOP_W-1:0]  mop;
  logic signed [GAIN_W-1:0] mul_gain;
  logic signed [PROD_W-1:0] prod;
  logic signed [GAIN_W-1:0] sat_val;
  logic signed [GAIN_W-1:0] volt_stage;
  logic signed [GAIN_W-1:0] cur_stage;

  logic xfer;
  logic accumulate;
  logic out_free;
  logic emit;

  assign smp[CH_VOLT]  = voltage_sample[SAMPLE_BITS-1:0];
  assign smp[CH_IREF]  = iref_sample[SAMPLE_BITS-1:0];
  assign smp[CH_IMEAS] = imeas_sample[SAMPLE_BITS-1:0];
  assign smp[CH_MAG]   = magnet_sample[SAMPLE_BITS-1:0];
  assign smp[CH_TEMP]  = temperature_sample[SAMPLE_BITS-1:0];

  assign in_ready   = (ctl.op == OP_ACCEPT);
  assign xfer       = in_valid && in_ready;
  assign accumulate = xfer && !command && (frames_held < CNT_W'(FRAME_DEPTH));
  assign out_free   = !out_valid || out_ready;
  assign emit       = (ctl.op == OP_EMIT) && out_free;

  assign stat.drain_go = xfer && command && (frames_held != '0);
  assign stat.div_busy = (step_cnt != STEP_W'(SAMPLE_BITS - 1));
  assign stat.out_busy = !out_free;

  // restoring divide, one quotient bit a cycle; the remainder starts from the
  // sum's top bits, which are always below the frame count
  always_comb begin
    trial    = {rem[REM_W-2:0], dshift[SAMPLE_BITS-1]};
    ge       = (trial >= REM_W'(frames_held));
    rem_next = ge ? trial - REM_W'(frames_held) : trial;
    quo_next = {quo[SAMPLE_BITS-2:0], ge};
  end

  always_comb begin
    if (ctl.op == OP_MUL_I) begin
      mop      = signed'({2'b00, avg[CH_IMEAS]}) - signed'({2'b00, avg[CH_IREF]});
      mul_gain = current_gain;
    end else begin
      mop      = signed'({2'b00, avg[CH_VOLT]});
      mul_gain = voltage_gain;
    end
  end

  // clamp to the signed 32-bit range
  always_comb begin
    if ((&prod[PROD_W-1:GAIN_W-1]) || !(|prod[PROD_W-1:GAIN_W-1])) begin
      sat_val = prod[GAIN_W-1:0];
    end else if (prod[PROD_W-1]) begin
      sat_val = {1'b1, {(GAIN_W-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(GAIN_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CH; i++) begin
        sums[i] <= '0;
      end
      frames_held <= '0;
    end else if (emit) begin
      for (int i = 0; i < NUM_CH; i++) begin
        sums[i] <= '0;
      end
      frames_held <= '0;
    end else if (accumulate) begin
      for (int i = 0; i < NUM_CH; i++) begin
        sums[i] <= sums[i] + SUM_W'(smp[i]);
      end
      frames_held <= frames_held + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_cnt <= '0;
    end else if (ctl.op == OP_DIV_LOAD) begin
      step_cnt <= '0;
    end else if (ctl.op == OP_DIV_STEP) begin
      step_cnt <= step_cnt + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_DIV_LOAD: begin
        rem    <= REM_W'(sums[ctl.ch][SUM_W-1:SAMPLE_BITS]);
        dshift <= sums[ctl.ch][SAMPLE_BITS-1:0];
        quo    <= '0;
      end
      OP_DIV_STEP: begin
        rem    <= rem_next;
        dshift <= {dshift[SAMPLE_BITS-2:0], 1'b0};
        quo    <= quo_next;
        if (!stat.div_busy) begin
          avg[ctl.ch] <= quo_next;
        end
      end
      OP_MUL_V, OP_MUL_I: begin
        prod <= mop * mul_gain;
      end
      OP_SAT_V: begin
        volt_stage <= sat_val;
      end
      OP_SAT_I: begin
        cur_stage <= sat_val;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      voltage_scaled      <= volt_stage;
      current_feedback    <= cur_stage;
      iref_average        <= avg[CH_IREF];
      imeas_average       <= avg[CH_IMEAS];
      magnet_average      <= avg[CH_MAG];
      temperature_average <= avg[CH_TEMP];
      frames_used         <= frames_held;
    end
  end

  `AFAS_ASSERT(a_depth_bound, frames_held <= CNT_W'(FRAME_DEPTH))
  `AFAS_ASSERT(a_drain_nonempty, (ctl.op != OP_ACCEPT) |-> (frames_held != '0))
  `AFAS_ASSERT(a_rem_bound, (ctl.op == OP_DIV_STEP) |-> (rem < REM_W'(frames_held)))
  `AFAS_ASSERT(a_emit_clears, emit |=> (out_valid && frames_held == '0))
  `AFAS_ASSERT_RST(a_reset_idle, rst |=> (!out_valid && frames_held == '0))

endmodule

/* rtl/adc_frame_average_scaler_core.sv */
// Five-channel block averager. An accumulate frame (command 0) adds its samples
// into per-channel sums; frames past 32 are dropped until the next drain. A
// drain (command 1) with frames held runs a 16-step control program: each
// channel goes through one shared bit-serial divider (1 load + 12 steps), then
// two 14x32 multiplies with saturation, then the result is loaded into the
// output register. The load waits while the previous result still waits on
// out_ready; a drain with no frames is consumed and gives no result. Input
// transfers are taken only between programs. Gains are Q16.16 at APB offsets
// 0x0 (voltage) and 0x4 (current).
module adc_frame_average_scaler_core
  import afas_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               command,
  input  logic [11:0]        voltage_sample,
  input  logic [11:0]        iref_sample,
  input  logic [11:0]        imeas_sample,
  input  logic [11:0]        magnet_sample,
  input  logic [11:0]        temperature_sample,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] voltage_scaled,
  output logic signed [31:0] current_feedback,
  output logic [11:0]        iref_average,
  output logic [11:0]        imeas_average,
  output logic [11:0]        magnet_average,
  output logic [11:0]        temperature_average,
  output logic [5:0]         frames_used
);

  logic signed [GAIN_W-1:0] voltage_gain;
  logic signed [GAIN_W-1:0] current_gain;
  logic                     reg_wr;
  ctl_t                     ctl;
  stat_t                    stat;

  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      voltage_gain <= GAIN_RESET;
      current_gain <= GAIN_RESET;
    end else if (reg_wr) begin
      if (paddr[2] == REG_IGAIN) begin
        current_gain <= pwdata;
      end else begin
        voltage_gain <= pwdata;
      end
    end
  end

  always_comb begin
    case (paddr[2])
      REG_VGAIN: prdata = voltage_gain;
      REG_IGAIN: prdata = current_gain;
      default:   prdata = '0;
    endcase
  end

  afas_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctl  (ctl)
  );

  afas_datapath u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .ctl                 (ctl),
    .stat                (stat),
    .voltage_gain        (voltage_gain),
    .current_gain        (current_gain),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .command             (command),
    .voltage_sample      (voltage_sample),
    .iref_sample         (iref_sample),
    .imeas_sample        (imeas_sample),
    .magnet_sample       (magnet_sample),
    .temperature_sample  (temperature_sample),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .voltage_scaled      (voltage_scaled),
    .current_feedback    (current_feedback),
    .iref_average        (iref_average),
    .imeas_average       (imeas_average),
    .magnet_average      (magnet_average),
    .temperature_average (temperature_average),
    .frames_used         (frames_used)
  );

endmodule

/* tb/sv/afas_tb_pkg.sv */
package afas_tb_pkg;
  import afas_pkg::*;

  localparam logic CMD_FRAME = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  // byte addresses on the register port
  localparam logic [2:0] ADDR_VGAIN = {REG_VGAIN, 2'b00};
  localparam logic [2:0] ADDR_IGAIN = {REG_IGAIN, 2'b00};

endpackage

/* tb/sv/average_scaler_checker.sv */
module average_scaler_checker
  import afas_pkg::*;
  import afas_tb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               command,
  input  logic [11:0]        voltage_sample,
  input  logic [11:0]        iref_sample,
  input  logic [11:0]        imeas_sample,
  input  logic [11:0]        magnet_sample,
  input  logic [11:0]        temperature_sample,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] voltage_scaled,
  input  logic signed [31:0] current_feedback,
  input  logic [11:0]        iref_average,
  input  logic [11:0]        imeas_average,
  input  logic [11:0]        magnet_average,
  input  logic [11:0]        temperature_average,
  input  logic [5:0]         frames_used,
  output int                 errors,
  output int                 pending
);

  typedef struct {
    logic signed [31:0] volt_scaled;
    logic signed [31:0] cur_fb;
    logic [11:0]        iref_avg;
    logic [11:0]        imeas_avg;
    logic [11:0]        mag_avg;
    logic [11:0]        temp_avg;
    logic [5:0]         frames;
  } averages_t;

  logic [SUM_W-1:0]         chan_sum [NUM_CH];
  logic [CNT_W-1:0]         frames_held;
  logic signed [GAIN_W-1:0] vgain;
  logic signed [GAIN_W-1:0] igain;
  averages_t                expected_averages [$];
  int                       error_count = 0;

  assign errors = error_count;

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch on %s: got %0d, want %0d", what, got, want);
    error_count++;
  endtask

  function automatic logic signed [31:0] clamp32(input longint x);
    if (x > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  always @(posedge clk) begin : track
    averages_t        want;
    logic [11:0]      smp [NUM_CH];
    logic [11:0]      avg [NUM_CH];
    int               diff;
    if (rst) begin
      foreach (chan_sum[c]) chan_sum[c] = '0;
      frames_held = '0;
      vgain = GAIN_RESET;
      igain = GAIN_RESET;
      expected_averages.delete();
      pending <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == ADDR_VGAIN) vgain = pwdata;
        else if (paddr == ADDR_IGAIN) igain = pwdata;
      end

      if (out_valid && out_ready) begin
        if (expected_averages.size() == 0) begin
          report("result transfer with nothing expected, frames_used", frames_used, 0);
        end else begin
          want = expected_averages.pop_front();
          if (voltage_scaled !== want.volt_scaled)
            report("voltage_scaled", voltage_scaled, want.volt_scaled);
          if (current_feedback !== want.cur_fb)
            report("current_feedback", current_feedback, want.cur_fb);
          if (iref_average !== want.iref_avg)
            report("iref_average", iref_average, want.iref_avg);
          if (imeas_average !== want.imeas_avg)
            report("imeas_average", imeas_average, want.imeas_avg);
          if (magnet_average !== want.mag_avg)
            report("magnet_average", magnet_average, want.mag_avg);
          if (temperature_average !== want.temp_avg)
            report("temperature_average", temperature_average, want.temp_avg);
          if (frames_used !== want.frames)
            report("frames_used", frames_used, want.frames);
        end
      end

      if (in_valid && in_ready) begin
        smp = '{voltage_sample, iref_sample, imeas_sample, magnet_sample, temperature_sample};
        if (command == CMD_FRAME) begin
          // a full accumulator drops the frame
          if (frames_held < FRAME_DEPTH) begin
            foreach (chan_sum[c]) chan_sum[c] = chan_sum[c] + SUM_W'(smp[c]);
            frames_held = frames_held + CNT_W'(1);
          end
        end else if (frames_held != 0) begin
          foreach (avg[c]) avg[c] = 12'(chan_sum[c] / SUM_W'(frames_held));
          diff = int'(avg[CH_IMEAS]) - int'(avg[CH_IREF]);
          want.volt_scaled = clamp32(longint'(avg[CH_VOLT]) * longint'(vgain));
          want.cur_fb      = clamp32(longint'(diff) * longint'(igain));
          want.iref_avg    = avg[CH_IREF];
          want.imeas_avg   = avg[CH_IMEAS];
          want.mag_avg     = avg[CH_MAG];
          want.temp_avg    = avg[CH_TEMP];
          want.frames      = 6'(frames_held);
          expected_averages.push_back(want);
          foreach (chan_sum[c]) chan_sum[c] = '0;
          frames_held = '0;
        end
      end

      pending <= expected_averages.size();
    end
  end

endmodule

/* tb/sv/tb_top.sv */
module tb_top;
  import afas_pkg::*;
  import afas_tb_pkg::*;

  localparam int DRAIN_LATENCY   = 70;
  localparam int HOLD_CYCLES     = 400;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int PHASES          = 7;
  localparam int ITEMS_PER_PHASE = 107;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid;
  logic               in_ready;
  logic               command;
  logic [11:0]        voltage_sample;
  logic [11:0]        iref_sample;
  logic [11:0]        imeas_sample;
  logic [11:0]        magnet_sample;
  logic [11:0]        temperature_sample;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] voltage_scaled;
  logic signed [31:0] current_feedback;
  logic [11:0]        iref_average;
  logic [11:0]        imeas_average;
  logic [11:0]        magnet_average;
  logic [11:0]        temperature_average;
  logic [5:0]         frames_used;
  int                 errors;
  int                 pending;

  bit hold_req  = 1'b0;
  bit tx_steady = 1'b1;
  bit rx_steady = 1'b1;
  int rx_stall;
  int idle_cycles  = 0;
  int frames_local = 0;

  adc_frame_average_scaler_core DUT (.*);

  average_scaler_checker u_average_check (.*);

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // no transfer of any kind for too long means a hang
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: random back-pressure, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    rx_stall  = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        rx_stall = HOLD_CYCLES;
      end
      if (rx_stall > 0) begin
        out_ready <= 1'b0;
        rx_stall--;
      end else if (rx_steady || $urandom_range(0, 3) != 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        rx_stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (tx_steady || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [11:0] pick_sample();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 12'h000;
    if (r == 1) return 12'hFFF;
    return 12'($urandom);
  endfunction

  task automatic send(input logic cmd, input logic [11:0] v, input logic [11:0] ir,
                      input logic [11:0] im, input logic [11:0] mg, input logic [11:0] tp);
    int gap;
    gap = pick_gap();
    in_valid           <= 1'b1;
    command            <= cmd;
    voltage_sample     <= v;
    iref_sample        <= ir;
    imeas_sample       <= im;
    magnet_sample      <= mg;
    temperature_sample <= tp;
    do @(posedge clk); while (!in_ready);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    send(CMD_DRAIN, 12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom),
         12'($urandom));
  endtask

  // wait until every result is out and any drain program has finished
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // well-formed runs of frames closed by a drain; some runs overfill the
  // accumulator, some drains find it empty
  task automatic run_phase(input int n);
    int done;
    int run;
    int r;
    done = 0;
    while (done < n) begin
      r = $urandom_range(0, 19);
      if (r < 2) run = 0;
      else if (r < 4) run = $urandom_range(30, 40);
      else run = $urandom_range(1, 8);
      repeat (run) begin
        send(CMD_FRAME, pick_sample(), pick_sample(), pick_sample(), pick_sample(),
             pick_sample());
        if (frames_local < FRAME_DEPTH) begin
          frames_local++;
          done++;
        end
      end
      drain();
      if (frames_local != 0) done++;
      frames_local = 0;
      if ($urandom_range(0, 7) == 0) drain();
    end
  endtask

  initial begin
    logic [31:0] vg;
    logic [31:0] ig;
    rst                = 1'b1;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    in_valid           = 1'b0;
    command            = CMD_FRAME;
    voltage_sample     = '0;
    iref_sample        = '0;
    imeas_sample       = '0;
    magnet_sample      = '0;
    temperature_sample = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed, reset gains
    drain();                                                // empty drain
    send(CMD_FRAME, 12'hFFF, 12'h000, 12'hFFF, 12'hFFF, 12'hFFF);
    drain();                                                // largest positive difference
    send(CMD_FRAME, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000);
    drain();
    send(CMD_FRAME, 12'hA5A, 12'hFFF, 12'h000, 12'h5A5, 12'h001);
    drain();                                                // largest negative difference
    send(CMD_FRAME, 12'h001, 12'h003, 12'h7FF, 12'h800, 12'hFFE);
    send(CMD_FRAME, 12'h001, 12'h004, 12'h800, 12'h7FF, 12'hFFF);
    send(CMD_FRAME, 12'h000, 12'h004, 12'h800, 12'h800, 12'hFFF);
    drain();                                                // truncating averages
    drain();                                                // empty again right after
    send(CMD_FRAME, 12'hFFF, 12'hFFE, 12'h555, 12'hAAA, 12'hFFF);
    send(CMD_FRAME, 12'hFFE, 12'hFFF, 12'hAAA, 12'h555, 12'hFFE);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        0: begin vg = 32'h7FFFFFFF; ig = 32'h80000000; end
        1: begin vg = 32'h80000000; ig = 32'h7FFFFFFF; end
        2: begin vg = 32'h00000000; ig = 32'hFFFFFFFF; end
        3: begin vg = $urandom; ig = $urandom; end
        4: begin
          vg = $urandom_range(0, 1 << 23) - (1 << 22);
          ig = $urandom_range(0, 1 << 23) - (1 << 22);
        end
        5: begin vg = 32'hFFFF0000; ig = 32'h00008000; end
        default: begin vg = GAIN_RESET; ig = $urandom_range(0, 1 << 21) - (1 << 20); end
      endcase
      write_reg(ADDR_VGAIN, vg);
      write_reg(ADDR_IGAIN, ig);
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      if (p == 2) begin
        // result side holds off while frames keep coming: input must stall
        tx_steady = 1'b1;
        hold_req  = 1'b1;
      end
      run_phase(ITEMS_PER_PHASE);
    end

    settle();
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* adc_frame_average_scaler_core.f */
+incdir+rtl
rtl/afas_pkg.sv
rtl/afas_seq.sv
rtl/afas_datapath.sv
rtl/adc_frame_average_scaler_core.sv
tb/sv/afas_tb_pkg.sv
tb/sv/average_scaler_checker.sv
tb/sv/tb_top.sv
